FILE: design/bla_pkg.sv
package bla_pkg;

    // Tree size and lifting depth
    localparam int NODES   = 4096;
    localparam int LEVELS  = 12;

    // Field widths fixed by the item formats
    localparam int NODE_W  = 12;
    localparam int DEPTH_W = 12;
    localparam int REL_W   = 2;

    // Derived memory geometry
    localparam int NODE_AW   = $clog2(NODES);
    localparam int ANC_DEPTH = NODES * LEVELS;
    localparam int ANC_AW    = $clog2(ANC_DEPTH);
    localparam int LVL_W     = $clog2(LEVELS);

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

    // Item codes
    localparam logic MODE_ATTACH = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_ERR      = 1'b1;
    localparam logic [REL_W-1:0] REL_NONE = 2'd0;
    localparam logic [REL_W-1:0] REL_A    = 2'd1;
    localparam logic [REL_W-1:0] REL_B    = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_in_item;

    typedef struct packed {
        logic              status;
        logic [NODE_W-1:0] lca_node;
        logic [REL_W-1:0]  relation;
    } t_out_item;

    // Depth store port request
    typedef struct packed {
        logic               en;
        logic               we;
        logic [NODE_AW-1:0] addr;
        logic [DEPTH_W-1:0] wdata;
    } t_dep_req;

    // Ancestor table port request
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ANC_AW-1:0] addr;
        logic [NODE_W-1:0] wdata;
    } t_anc_req;

    // Result handoff from the sequencer to the output stage
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_res_push;

    function automatic logic [NODE_AW-1:0] dep_addr(input logic [NODE_W-1:0] node);
        return NODE_AW'(node);
    endfunction

    function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                    input logic [LVL_W-1:0] lvl);
        int row;
        row = int'(node) * LEVELS + int'(lvl);
        return ANC_AW'(row);
    endfunction

endpackage

FILE: design/binary_lifting_ancestor_query.sv
// Binary-lifting ancestor query block. Each item either attaches a child node
// under an attached parent (parent 0 makes it a root) or asks for the lowest
// common ancestor of two nodes and how they relate; every item yields exactly
// one result. Nodes must be attached parent-first. Depths live in a 4096-entry
// single-port RAM and the 2^k ancestor rows in a 49152-entry single-port RAM,
// both with registered reads; all work is sequenced through these
// two ports, one item at a time. After reset a clearing pass writes the depth
// RAM, one entry a cycle; items are stalled meanwhile. An accepted attach
// writes the depth and level 0, then makes one ancestor read and one write per
// level while the parent chain lasts and a single write per level above it. A
// query makes a table read, a depth read and a compare per level on the first
// climb and two table reads and a compare per level on the joint climb, which
// it skips when the first climb already lands on the other node. A failed
// check goes straight to the result. A new item is taken once the previous
// result is in the output register, which holds it while the output stalls.
module binary_lifting_ancestor_query
    import bla_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic               ready;
    logic               res_room;
    t_dep_req           dep_req;
    t_anc_req           anc_req;
    logic [DEPTH_W-1:0] dep_rdata;
    logic [NODE_W-1:0]  anc_rdata;
    t_res_push          res;
    logic               r_out_valid;
    t_out_item          r_out_item;

    bla_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (NODES)
    ) u_dep_ram (
        .i_clk   (i_clk),
        .i_en    (dep_req.en),
        .i_we    (dep_req.we),
        .i_addr  (dep_req.addr),
        .i_wdata (dep_req.wdata),
        .o_rdata (dep_rdata)
    );

    bla_ram #(
        .WIDTH (NODE_W),
        .DEPTH (ANC_DEPTH)
    ) u_anc_ram (
        .i_clk   (i_clk),
        .i_en    (anc_req.en),
        .i_we    (anc_req.we),
        .i_addr  (anc_req.addr),
        .i_wdata (anc_req.wdata),
        .o_rdata (anc_rdata)
    );

    bla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_ready     (ready),
        .o_dep_req   (dep_req),
        .i_dep_rdata (dep_rdata),
        .o_anc_req   (anc_req),
        .i_anc_rdata (anc_rdata),
        .o_res       (res),
        .i_res_room  (res_room)
    );

    // Output register takes a new item when empty or being drained
    assign res_room = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_room) begin
            r_out_valid <= res.valid;
        end
    end

    // Hold the result payload until taken
    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_item <= res.item;
        end
    end

    assign o_in_stall  = !ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> res_room)
        else $error("result pushed into a full output register");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !res.valid))
        else $error("sequencer not busy after accepting an item");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == ST_ERR))
        |-> ((o_out_item.lca_node == '0) && (o_out_item.relation == REL_NONE)))
        else $error("rejected item carries an answer");

    a_rel_has_lca: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.relation != REL_NONE))
        |-> ((o_out_item.lca_node != '0) && (o_out_item.relation != 2'd3)))
        else $error("relation reported without an ancestor");
`endif

endmodule

FILE: design/bla_ram.sv
module bla_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: write or registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bla_ctrl.sv
module bla_ctrl
    import bla_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_item,
    output logic               o_ready,
    output t_dep_req           o_dep_req,
    input  logic [DEPTH_W-1:0] i_dep_rdata,
    output t_anc_req           o_anc_req,
    input  logic [NODE_W-1:0]  i_anc_rdata,
    output t_res_push          o_res,
    input  logic               i_res_room
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RDA,
        S_RDB,
        S_CHK,
        S_AT_RD,
        S_AT_WR,
        S_L1_RD,
        S_L1_DEP,
        S_L1_CMP,
        S_EQ,
        S_L2_RX,
        S_L2_RY,
        S_L2_CMP,
        S_L2_UP,
        S_L2_LCA,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [NODE_AW-1:0] r_cnt;
    logic               r_mode;
    logic [NODE_W-1:0]  r_a;
    logic [NODE_W-1:0]  r_b;
    logic [DEPTH_W-1:0] r_da;
    logic [DEPTH_W-1:0] r_dy;
    logic [NODE_W-1:0]  r_x;
    logic [NODE_W-1:0]  r_y;
    logic [NODE_W-1:0]  r_t;
    logic [LVL_W-1:0]   r_k;
    logic               r_status;
    logic [NODE_W-1:0]  r_lca;

    logic               a_ok;
    logic               b_usable;
    logic [DEPTH_W-1:0] par_depth;
    logic               attach_ok;
    logic               query_ok;
    logic               lvl_last;
    logic [NODE_W-1:0]  l2_ty;
    logic [REL_W-1:0]   rel;

    // Check the item once both depths are back (depth of node_b on the read port)
    always_comb begin
        a_ok      = (r_a != '0) && (int'(r_a) < NODES);
        b_usable  = (r_b != '0) && (int'(r_b) < NODES) && (i_dep_rdata != '0);
        par_depth = (r_b == '0) ? '0 : i_dep_rdata;
        attach_ok = a_ok && (r_da == '0) && ((r_b == '0) || b_usable)
                    && (par_depth < DEPTH_MAX);
        query_ok  = a_ok && (r_da != '0) && b_usable;
        lvl_last  = (r_k == LVL_W'(LEVELS - 1));
        l2_ty     = (r_y == '0) ? '0 : i_anc_rdata;
    end

    // Drive memory ports from the current step
    always_comb begin
        o_dep_req = '0;
        o_anc_req = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_dep_req.en   = 1'b1;
                o_dep_req.we   = 1'b1;
                o_dep_req.addr = r_cnt;
            end
            S_RDA: begin
                o_dep_req.en   = 1'b1;
                o_dep_req.addr = dep_addr(r_a);
            end
            S_RDB: begin
                o_dep_req.en   = 1'b1;
                o_dep_req.addr = dep_addr(r_b);
            end
            S_CHK: begin
                if ((r_mode == MODE_ATTACH) && attach_ok) begin
                    o_dep_req.en    = 1'b1;
                    o_dep_req.we    = 1'b1;
                    o_dep_req.addr  = dep_addr(r_a);
                    o_dep_req.wdata = par_depth + 1'b1;
                    o_anc_req.en    = 1'b1;
                    o_anc_req.we    = 1'b1;
                    o_anc_req.addr  = anc_addr(r_a, '0);
                    o_anc_req.wdata = r_b;
                end
            end
            S_AT_RD: begin
                o_anc_req.en = 1'b1;
                if (r_x == '0) begin
                    o_anc_req.we   = 1'b1;
                    o_anc_req.addr = anc_addr(r_a, r_k);
                end else begin
                    o_anc_req.addr = anc_addr(r_x, r_k - 1'b1);
                end
            end
            S_AT_WR: begin
                o_anc_req.en    = 1'b1;
                o_anc_req.we    = 1'b1;
                o_anc_req.addr  = anc_addr(r_a, r_k);
                o_anc_req.wdata = i_anc_rdata;
            end
            S_L1_RD, S_L2_RX: begin
                o_anc_req.en   = 1'b1;
                o_anc_req.addr = anc_addr(r_x, r_k);
            end
            S_L1_DEP: begin
                o_dep_req.en   = 1'b1;
                o_dep_req.addr = dep_addr(i_anc_rdata);
            end
            S_L2_RY: begin
                o_anc_req.en   = 1'b1;
                o_anc_req.addr = anc_addr(r_y, r_k);
            end
            S_L2_UP: begin
                o_anc_req.en   = 1'b1;
                o_anc_req.addr = anc_addr(r_x, '0);
            end
            default: begin
                o_dep_req = '0;
                o_anc_req = '0;
            end
        endcase
    end

    // Sequence one item through the two memories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == NODE_AW'(NODES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode  <= i_in_item.mode;
                        r_a     <= i_in_item.node_a;
                        r_b     <= i_in_item.node_b;
                        r_state <= S_RDA;
                    end
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_da    <= i_dep_rdata;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_lca    <= '0;
                    r_status <= ST_ERR;
                    r_state  <= S_DONE;
                    if (r_mode == MODE_ATTACH) begin
                        if (attach_ok) begin
                            r_status <= ST_OK;
                            r_x      <= r_b;
                            r_k      <= LVL_W'(1);
                            r_state  <= S_AT_RD;
                        end
                    end else if (query_ok) begin
                        r_status <= ST_OK;
                        // Put the deeper node in x
                        if (r_da < i_dep_rdata) begin
                            r_x  <= r_b;
                            r_y  <= r_a;
                            r_dy <= r_da;
                        end else begin
                            r_x  <= r_a;
                            r_y  <= r_b;
                            r_dy <= i_dep_rdata;
                        end
                        r_k     <= LVL_W'(LEVELS - 1);
                        r_state <= S_L1_RD;
                    end
                end
                S_AT_RD: begin
                    if (r_x != '0) begin
                        r_state <= S_AT_WR;
                    end else if (lvl_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_AT_WR: begin
                    r_x <= i_anc_rdata;
                    if (lvl_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_AT_RD;
                    end
                end
                S_L1_RD: begin
                    r_state <= S_L1_DEP;
                end
                S_L1_DEP: begin
                    r_t     <= i_anc_rdata;
                    r_state <= S_L1_CMP;
                end
                S_L1_CMP: begin
                    // Lift x while it stays at or below the level of y
                    if (i_dep_rdata >= r_dy) begin
                        r_x <= r_t;
                    end
                    if (r_k == '0) begin
                        r_state <= S_EQ;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_L1_RD;
                    end
                end
                S_EQ: begin
                    if (r_x == r_y) begin
                        r_lca   <= r_x;
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= LVL_W'(LEVELS - 1);
                        r_state <= S_L2_RX;
                    end
                end
                S_L2_RX: begin
                    r_state <= S_L2_RY;
                end
                S_L2_RY: begin
                    r_t     <= (r_x == '0) ? '0 : i_anc_rdata;
                    r_state <= S_L2_CMP;
                end
                S_L2_CMP: begin
                    // Lift both while their ancestors differ
                    if (r_t != l2_ty) begin
                        r_x <= r_t;
                        r_y <= l2_ty;
                    end
                    if (r_k == '0) begin
                        r_state <= S_L2_UP;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_L2_RX;
                    end
                end
                S_L2_UP: begin
                    r_state <= S_L2_LCA;
                end
                S_L2_LCA: begin
                    r_lca   <= (r_x == '0) ? '0 : i_anc_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_room) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Relate the answer to the queried nodes
    always_comb begin
        rel = REL_NONE;
        if ((r_mode == MODE_QUERY) && (r_status == ST_OK)) begin
            if (r_lca == r_a) begin
                rel = REL_A;
            end else if (r_lca == r_b) begin
                rel = REL_B;
            end
        end
    end

    assign o_ready             = (r_state == S_IDLE);
    assign o_res.valid         = (r_state == S_DONE) && i_res_room;
    assign o_res.item.status   = r_status;
    assign o_res.item.lca_node = r_lca;
    assign o_res.item.relation = rel;

endmodule

FILE: tb/binary_lifting_ancestor_query_test.sv
`timescale 1ns / 100ps

module binary_lifting_ancestor_query_test
    import bla_pkg::*;
();

    localparam int RAND_N       = 1430;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_PCT     = 38;

    // One row of directed stimulus; known is used only where use_known is set
    typedef struct packed {
        logic      use_known;
        t_in_item  item;
        t_out_item known;
    } t_dir_row;

    localparam t_out_item RES_ERR  = '{ST_ERR, 12'd0, REL_NONE};
    localparam t_out_item RES_DONE = '{ST_OK, 12'd0, REL_NONE};

    localparam int DIR_N = 21;
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        // empty forest: everything is rejected
        '{1'b1, '{MODE_QUERY,  12'd1,    12'd2},    RES_ERR},
        '{1'b1, '{MODE_ATTACH, 12'd0,    12'd0},    RES_ERR},
        '{1'b1, '{MODE_ATTACH, 12'd1,    12'd4095}, RES_ERR},
        // build two trees, with a repeat attach in between
        '{1'b1, '{MODE_ATTACH, 12'd1,    12'd0},    RES_DONE},
        '{1'b1, '{MODE_ATTACH, 12'd1,    12'd0},    RES_ERR},
        '{1'b1, '{MODE_ATTACH, 12'd4095, 12'd1},    RES_DONE},
        '{1'b1, '{MODE_ATTACH, 12'd2,    12'd4095}, RES_DONE},
        '{1'b1, '{MODE_ATTACH, 12'd3,    12'd1},    RES_DONE},
        '{1'b1, '{MODE_ATTACH, 12'd4,    12'd3},    RES_DONE},
        '{1'b1, '{MODE_ATTACH, 12'd2048, 12'd0},    RES_DONE},
        '{1'b1, '{MODE_ATTACH, 12'd2047, 12'd2048}, RES_DONE},
        '{1'b1, '{MODE_ATTACH, 12'd4094, 12'd4093}, RES_ERR},
        '{1'b1, '{MODE_ATTACH, 12'd2,    12'd2},    RES_ERR},
        // queries checked by the predictor
        '{1'b0, '{MODE_QUERY,  12'd2,    12'd4},    RES_DONE},
        '{1'b0, '{MODE_QUERY,  12'd1,    12'd2},    RES_DONE},
        '{1'b0, '{MODE_QUERY,  12'd2,    12'd4095}, RES_DONE},
        '{1'b0, '{MODE_QUERY,  12'd4095, 12'd4095}, RES_DONE},
        '{1'b0, '{MODE_QUERY,  12'd2,    12'd2047}, RES_DONE},
        // queries naming node 0 or an unattached node
        '{1'b1, '{MODE_QUERY,  12'd0,    12'd1},    RES_ERR},
        '{1'b1, '{MODE_QUERY,  12'd1,    12'd0},    RES_ERR},
        '{1'b1, '{MODE_QUERY,  12'd4095, 12'd100},  RES_ERR}
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // Predicted forest
    logic [DEPTH_W-1:0] node_depth [NODES];
    logic [NODE_W-1:0]  anc_row    [NODES][LEVELS];

    // Sender's view of which nodes end up attached, in issue order
    bit                planned [NODES];
    logic [NODE_W-1:0] attached_nodes [$];
    logic [NODE_W-1:0] chain_tip;

    t_dir_row  offer_q [$];
    t_out_item lca_results_q [$];

    logic idle_on  = 1'b1;
    logic hold_ask = 1'b0;
    int   items_taken  = 0;
    int   results_seen = 0;
    int   fail_count   = 0;
    int   quiet_cycles = 0;
    int   n_attach = 0;
    int   n_query  = 0;
    int   n_reject = 0;
    int   rel_seen [3] = '{0, 0, 0};

    binary_lifting_ancestor_query dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // 2^k-th ancestor, with node 0 standing for no node
    function automatic logic [NODE_W-1:0] hop(input logic [NODE_W-1:0] n, input int k);
        return (n == '0) ? '0 : anc_row[n][k];
    endfunction

    // Apply one item to the predicted forest and return its result
    function automatic t_out_item lca_predict(input t_in_item it);
        t_out_item          res;
        logic [NODE_W-1:0]  x, y, tx, ty;
        logic [DEPTH_W-1:0] pd;
        logic               ok;
        res = RES_ERR;
        if (it.mode == MODE_ATTACH) begin
            ok = (it.node_a != '0) && (node_depth[it.node_a] == '0);
            pd = '0;
            if (it.node_b != '0) begin
                if (node_depth[it.node_b] == '0)
                    ok = 1'b0;
                else
                    pd = node_depth[it.node_b];
            end
            if (pd >= DEPTH_MAX)
                ok = 1'b0;
            if (ok) begin
                node_depth[it.node_a] = pd + 1'b1;
                anc_row[it.node_a][0] = it.node_b;
                for (int k = 1; k < LEVELS; k++)
                    anc_row[it.node_a][k] = hop(anc_row[it.node_a][k-1], k - 1);
                res.status = ST_OK;
            end
        end else if (it.node_a != '0 && it.node_b != '0 &&
                     node_depth[it.node_a] != '0 && node_depth[it.node_b] != '0) begin
            x = it.node_a;
            y = it.node_b;
            if (node_depth[x] < node_depth[y]) begin
                x = it.node_b;
                y = it.node_a;
            end
            // lift the deeper node to the other's level
            for (int k = LEVELS - 1; k >= 0; k--) begin
                tx = hop(x, k);
                if (node_depth[tx] >= node_depth[y])
                    x = tx;
            end
            // lift both while their ancestors differ
            if (x != y) begin
                for (int k = LEVELS - 1; k >= 0; k--) begin
                    tx = hop(x, k);
                    ty = hop(y, k);
                    if (tx != ty) begin
                        x = tx;
                        y = ty;
                    end
                end
                x = hop(x, 0);
            end
            res.status   = ST_OK;
            res.lca_node = x;
            if (x == it.node_a)
                res.relation = REL_A;
            else if (x == it.node_b)
                res.relation = REL_B;
            else
                res.relation = REL_NONE;
        end
        return res;
    endfunction

    // Track attaches that will succeed, so random items can be well formed
    function automatic void plan_item(input t_in_item it);
        if (it.mode == MODE_ATTACH && it.node_a != '0 && !planned[it.node_a] &&
            (it.node_b == '0 || planned[it.node_b])) begin
            planned[it.node_a] = 1'b1;
            attached_nodes.push_back(it.node_a);
            chain_tip = it.node_a;
        end
    endfunction

    function automatic logic [NODE_W-1:0] fresh_node();
        logic [NODE_W-1:0] n;
        do
            n = NODE_W'($urandom_range(NODES - 1, 1));
        while (planned[n]);
        return n;
    endfunction

    function automatic logic [NODE_W-1:0] any_attached();
        if (attached_nodes.size() == 0)
            return '0;
        return attached_nodes[$urandom_range(attached_nodes.size() - 1)];
    endfunction

    // Mostly good attaches and queries, some noise
    function automatic t_in_item rand_item();
        t_in_item it;
        int       roll;
        int       pick;
        roll = $urandom_range(99);
        pick = $urandom_range(99);
        if (roll < 40) begin
            it.mode   = MODE_ATTACH;
            it.node_a = fresh_node();
            if (pick < 15)
                it.node_b = '0;
            else if (pick < 60)
                it.node_b = chain_tip;
            else
                it.node_b = any_attached();
        end else if (roll < 85) begin
            it.mode   = MODE_QUERY;
            it.node_a = any_attached();
            it.node_b = (pick < 10) ? it.node_a : any_attached();
        end else begin
            it.mode   = logic'($urandom_range(1));
            it.node_a = ($urandom_range(3) == 0) ? '0 : NODE_W'($urandom_range(NODES - 1));
            it.node_b = ($urandom_range(3) == 0) ? '0 : NODE_W'($urandom_range(NODES - 1));
            if (it.mode == MODE_ATTACH && pick < 30)
                it.node_a = any_attached();
        end
        return it;
    endfunction

    // Offer one item and hold it until it is taken
    task automatic offer(input t_in_item it, input logic use_known, input t_out_item known);
        offer_q.push_back(t_dir_row'{use_known, it, known});
        plan_item(it);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic check_field(input string name, input logic [NODE_W-1:0] want,
                               input logic [NODE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare results in order, then predict each item taken
    always @(posedge i_clk) begin : scoreboard
        t_dir_row  row;
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (lca_results_q.size() == 0) begin
                    $error("result with no expectation waiting");
                    fail_count++;
                end else begin
                    want = lca_results_q.pop_front();
                    check_field("status", NODE_W'(want.status), NODE_W'(o_out_item.status));
                    check_field("lca_node", want.lca_node, o_out_item.lca_node);
                    check_field("relation", NODE_W'(want.relation),
                                NODE_W'(o_out_item.relation));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                items_taken++;
                row  = offer_q.pop_front();
                want = lca_predict(i_in_item);
                if (row.use_known)
                    want = row.known;
                lca_results_q.push_back(want);
                if (want.status == ST_ERR)
                    n_reject++;
                else if (i_in_item.mode == MODE_ATTACH)
                    n_attach++;
                else begin
                    n_query++;
                    rel_seen[want.relation]++;
                end
            end
        end
    end

    // Stall the output at random, or for a long hold when asked
    initial begin : out_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_ask) begin
                hold_ask  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item it;
        int       chain_len;
        for (int n = 0; n < NODES; n++)
            node_depth[n] = '0;
        chain_tip = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        for (int r = 0; r < DIR_N; r++)
            offer(DIR_ROWS[r].item, DIR_ROWS[r].use_known, DIR_ROWS[r].known);

        // open with one long chain, then mixed traffic
        chain_len = $urandom_range(400, 200);
        for (int n = 0; n < RAND_N; n++) begin
            if (n == 500)
                idle_on = 1'b0;
            if (n == 700)
                idle_on = 1'b1;
            if (n == 850)
                hold_ask = 1'b1;
            if (n == 1100) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (results_seen < items_taken);
            end
            if (n < chain_len) begin
                it.mode   = MODE_ATTACH;
                it.node_a = fresh_node();
                it.node_b = chain_tip;
            end else begin
                it = rand_item();
            end
            offer(it, 1'b0, RES_DONE);
        end

        // drain
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_seen < items_taken);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (lca_results_q.size() != 0) begin
            $error("%0d expected results never arrived", lca_results_q.size());
            fail_count++;
        end

        $display("Covered %0d good attaches, %0d good queries, %0d rejected items.",
                 n_attach, n_query, n_reject);
        $display("Query relations: %0d unrelated, %0d first above, %0d second above.",
                 rel_seen[REL_NONE], rel_seen[REL_A], rel_seen[REL_B]);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
